// ===== src/ssg_pkg.sv =====
// shared types and constants for the striped scatter-gather splitter
package ssg_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_TARGETS_DEF = 64;

    localparam logic [1:0] KIND_PUSH_MEM  = 2'd0;
    localparam logic [1:0] KIND_PUSH_FILE = 2'd1;
    localparam logic [1:0] KIND_REQUEST   = 2'd2;
    localparam logic [1:0] KIND_CLEAR     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIECE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic REG_STRIPE_BYTES = 1'b0;
    localparam logic REG_TARGET_COUNT = 1'b1;

    // tdata carries everything except kind and status, which travel on tuser
    localparam int IN_BITS  = 64 + 40 + 63 + 40;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 6 + 64 + 63 + 40;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [39:0] file_length;
        logic [62:0] file_offset;
        logic [39:0] mem_length;
        logic [63:0] mem_address;
        logic [1:0]  kind;
    } in_item_t;

    typedef struct packed {
        logic [39:0] piece_length;
        logic [62:0] piece_offset;
        logic [63:0] piece_address;
        logic [5:0]  target;
        logic [1:0]  status;
    } out_item_t;

endpackage

// ===== src/striped_scatter_gather_splitter.sv =====
// striped scatter-gather splitter top level
//
// s_axis carries one request per item: s_axis_tuser holds the kind (push a
// memory segment, push a file extent, ask for the next piece, clear both
// queues) and s_axis_tdata the segment and extent fields. m_axis returns one
// result per request with the status on m_axis_tuser. cfg_we/cfg_index/cfg_data
// write stripe_bytes (index 0) and target_count (index 1); the user is to write
// them only while the block is idle, which the block itself does not enforce.
// Pushes, clears and requests that find a queue empty have their result valid
// in the cycle after acceptance. A piece request reads the heads, runs a
// restoring divider over the 63-bit file offset, one quotient bit per cycle,
// then a restoring modulo of the 63-bit stripe index by the target count
// through the same subtractor, then picks the length and updates the queues.
// s_axis_tready is low while a request is in work and while a result waits.
// Reset empties both queues, clears the used counters and loads
// stripe_bytes = 1048576 and target_count = 1. A stalled receiver holds the
// result in the output register; no further request is taken until it goes.
module striped_scatter_gather_splitter #(
    parameter int QUEUE_DEPTH = ssg_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_TARGETS = ssg_pkg::MAX_TARGETS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // kind
    input  logic [1:0]               s_axis_tuser,
    // mem_address, mem_length, file_offset, file_length (lowest first)
    input  logic [ssg_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // status
    output logic [1:0]               m_axis_tuser,
    // target, piece_address, piece_offset, piece_length (lowest first)
    output logic [ssg_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [30:0]              cfg_data
);
    import ssg_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(MAX_TARGETS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;

    logic [63:0] mq_addr [QUEUE_DEPTH];
    logic [39:0] mq_len  [QUEUE_DEPTH];
    logic [62:0] fq_off  [QUEUE_DEPTH];
    logic [39:0] fq_len  [QUEUE_DEPTH];

    logic [2:0]    state_reg;
    logic [PW-1:0] mem_head_reg, file_head_reg;
    logic [FW-1:0] mem_fill_reg, file_fill_reg;
    logic [39:0]   mem_used_reg, file_used_reg;
    logic [30:0]   stripe_reg;
    logic [6:0]    tcount_reg;

    in_item_t      in_item;
    logic [63:0]   h_addr_reg;
    logic [39:0]   h_mlen_reg, h_flen_reg;
    logic [62:0]   off_reg;
    logic [62:0]   quo_reg;
    logic [31:0]   rem_reg;
    logic [5:0]    cnt_reg;
    logic [30:0]   sb_reg;
    logic [CW-1:0] tc_reg;
    logic [39:0]   len_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;
    out_item_t     idle_result;

    assign in_item = in_item_t'({s_axis_tdata[IN_BITS-1:0], s_axis_tuser});
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_reg.status;
    assign m_axis_tdata = {{(OUT_W - OUT_BITS){1'b0}}, out_reg[OUT_BITS+1:2]};

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // shared subtractor: restoring step for both divide and modulo
    logic [31:0] sub_a, sub_b, shifted;
    logic [32:0] sub_d;
    logic        div_bit;
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            shifted = {rem_reg[30:0], off_reg[6'd62 - cnt_reg]};
            sub_b   = {1'b0, sb_reg};
        end
        else
        begin
            shifted = {rem_reg[30:0], quo_reg[6'd62 - cnt_reg]};
            sub_b   = {{(32 - CW){1'b0}}, tc_reg};
        end
        sub_a   = shifted;
        sub_d   = {1'b0, sub_a} - {1'b0, sub_b};
        div_bit = !sub_d[32];
    end

    // remainder of the division is parked here before the modulo pass
    logic [31:0] stripe_rem_reg;
    logic [39:0] stripe_left, file_left, mem_left, len_pick;
    logic [39:0] mem_used_sum, file_used_sum;
    always_comb
    begin
        stripe_left = 40'({1'b0, sb_reg}) - 40'(stripe_rem_reg);
        file_left   = h_flen_reg - file_used_reg;
        mem_left    = h_mlen_reg - mem_used_reg;
        len_pick    = file_left;
        if (stripe_left < len_pick)
            len_pick = stripe_left;
        if (mem_left < len_pick)
            len_pick = mem_left;
        mem_used_sum  = mem_used_reg + len_reg;
        file_used_sum = file_used_reg + len_reg;
    end

    // result of requests answered straight from idle
    always_comb
    begin
        idle_result = '0;
        case (in_item.kind)
            KIND_PUSH_MEM:
                if (mem_fill_reg == FW'(QUEUE_DEPTH))
                    idle_result.status = ST_FULL;
            KIND_PUSH_FILE:
                if (file_fill_reg == FW'(QUEUE_DEPTH))
                    idle_result.status = ST_FULL;
            KIND_REQUEST:
                if (mem_fill_reg == '0 || file_fill_reg == '0)
                    idle_result.status = ST_EMPTY;
            default: ;
        endcase
    end

    logic [PW-1:0] mem_tail, file_tail;
    always_comb
    begin
        mem_tail  = PW'((FW + 1)'(mem_head_reg) + (FW + 1)'(mem_fill_reg));
        file_tail = PW'((FW + 1)'(file_head_reg) + (FW + 1)'(file_fill_reg));
        if (QUEUE_DEPTH != (1 << PW))
        begin
            if ((FW + 1)'(mem_head_reg) + (FW + 1)'(mem_fill_reg) >= (FW + 1)'(QUEUE_DEPTH))
                mem_tail = PW'((FW + 1)'(mem_head_reg) + (FW + 1)'(mem_fill_reg)
                    - (FW + 1)'(QUEUE_DEPTH));
            if ((FW + 1)'(file_head_reg) + (FW + 1)'(file_fill_reg) >= (FW + 1)'(QUEUE_DEPTH))
                file_tail = PW'((FW + 1)'(file_head_reg) + (FW + 1)'(file_fill_reg)
                    - (FW + 1)'(QUEUE_DEPTH));
        end
    end

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        begin
            r = p + PW'(1);
            if ({1'b0, p} == (PW + 1)'(QUEUE_DEPTH - 1))
                r = '0;
            return r;
        end
    endfunction

    // queue storage, written on push and read into head registers
    always_ff @(posedge clk)
    begin
        if (accept && in_item.kind == KIND_PUSH_MEM && mem_fill_reg != FW'(QUEUE_DEPTH))
        begin
            mq_addr[mem_tail] <= in_item.mem_address;
            mq_len[mem_tail]  <= in_item.mem_length;
        end
        if (accept && in_item.kind == KIND_PUSH_FILE && file_fill_reg != FW'(QUEUE_DEPTH))
        begin
            fq_off[file_tail] <= in_item.file_offset;
            fq_len[file_tail] <= in_item.file_length;
        end
        if (state_reg == S_READ)
        begin
            h_addr_reg <= mq_addr[mem_head_reg];
            h_mlen_reg <= mq_len[mem_head_reg];
            h_flen_reg <= fq_len[file_head_reg];
            off_reg    <= fq_off[file_head_reg] + {23'd0, file_used_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mem_head_reg   <= '0;
            file_head_reg  <= '0;
            mem_fill_reg   <= '0;
            file_fill_reg  <= '0;
            mem_used_reg   <= '0;
            file_used_reg  <= '0;
            stripe_reg     <= 31'd1048576;
            tcount_reg     <= 7'd1;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            sb_reg         <= 31'd1;
            tc_reg         <= CW'(1);
            rem_reg        <= '0;
            quo_reg        <= '0;
            cnt_reg        <= '0;
            stripe_rem_reg <= '0;
            len_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STRIPE_BYTES: stripe_reg <= cfg_data;
                    REG_TARGET_COUNT: tcount_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_reg <= idle_result;
                        sb_reg  <= (stripe_reg == '0) ? 31'd1 : stripe_reg;
                        if (tcount_reg == '0)
                            tc_reg <= CW'(1);
                        else if (32'(tcount_reg) > 32'(MAX_TARGETS))
                            tc_reg <= CW'(MAX_TARGETS);
                        else
                            tc_reg <= CW'(tcount_reg);
                        case (in_item.kind)
                            KIND_PUSH_MEM:
                            begin
                                if (mem_fill_reg != FW'(QUEUE_DEPTH))
                                    mem_fill_reg <= mem_fill_reg + FW'(1);
                                out_valid_reg <= 1'b1;
                            end
                            KIND_PUSH_FILE:
                            begin
                                if (file_fill_reg != FW'(QUEUE_DEPTH))
                                    file_fill_reg <= file_fill_reg + FW'(1);
                                out_valid_reg <= 1'b1;
                            end
                            KIND_REQUEST:
                            begin
                                if (mem_fill_reg == '0 || file_fill_reg == '0)
                                    out_valid_reg <= 1'b1;
                                else
                                    state_reg <= S_READ;
                            end
                            default:
                            begin
                                mem_head_reg  <= '0;
                                file_head_reg <= '0;
                                mem_fill_reg  <= '0;
                                file_fill_reg <= '0;
                                mem_used_reg  <= '0;
                                file_used_reg <= '0;
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    quo_reg[6'd62 - cnt_reg] <= div_bit;
                    if (cnt_reg == 6'd62)
                    begin
                        // park the stripe remainder, restart for the modulo
                        stripe_rem_reg <= div_bit ? sub_d[31:0] : shifted;
                        rem_reg        <= '0;
                        cnt_reg        <= '0;
                        state_reg      <= S_MOD;
                    end
                    else
                    begin
                        rem_reg <= div_bit ? sub_d[31:0] : shifted;
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_MOD:
                begin
                    rem_reg <= div_bit ? sub_d[31:0] : shifted;
                    if (cnt_reg == 6'd62)
                        state_reg <= S_LEN;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_LEN:
                begin
                    len_reg   <= len_pick;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    out_reg.status        <= ST_PIECE;
                    out_reg.target        <= 6'(rem_reg);
                    out_reg.piece_address <= h_addr_reg + {24'd0, mem_used_reg};
                    out_reg.piece_offset  <= off_reg;
                    out_reg.piece_length  <= len_reg;
                    out_valid_reg         <= 1'b1;
                    state_reg             <= S_IDLE;
                    if (mem_used_sum >= h_mlen_reg)
                    begin
                        mem_used_reg <= '0;
                        mem_head_reg <= ptr_inc(mem_head_reg);
                        mem_fill_reg <= mem_fill_reg - FW'(1);
                    end
                    else
                        mem_used_reg <= mem_used_sum;
                    if (file_used_sum >= h_flen_reg)
                    begin
                        file_used_reg <= '0;
                        file_head_reg <= ptr_inc(file_head_reg);
                        file_fill_reg <= file_fill_reg - FW'(1);
                    end
                    else
                        file_used_reg <= file_used_sum;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_fill_reg <= FW'(QUEUE_DEPTH) && file_fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("ready while a request is in work");
    a_piece_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (mem_fill_reg != '0 && file_fill_reg != '0))
        else $error("piece cut from an empty queue");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (rem_reg < 32'(tc_reg)))
        else $error("target beyond count");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the striped scatter-gather splitter
`timescale 1ns / 100ps
module testbench;
    import ssg_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [1:0] s_axis_tuser = '0;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [1:0] m_axis_tuser;
    logic [OUT_W-1:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [30:0] cfg_data = '0;

    striped_scatter_gather_splitter dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [63:0] seg_addr [DEPTH];
    logic [39:0] seg_len [DEPTH];
    logic [62:0] ext_off [DEPTH];
    logic [39:0] ext_len [DEPTH];
    int seg_head, seg_fill, ext_head, ext_fill;
    logic [39:0] seg_used, ext_used;
    logic [30:0] stripe_reg;
    logic [6:0] targets_reg;

    in_item_t request_queue[$];
    out_item_t expected_results[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    task automatic report(input string what, input logic [199:0] got, input logic [199:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task automatic add_request(input in_item_t r);
        request_queue = {request_queue, r};
    endtask

    function automatic out_item_t split_step(input in_item_t r);
        out_item_t o;
        logic [63:0] sb, tc, off, left, len;
        int slot;
        o = '0;
        o.status = ST_OK;
        case (r.kind)
            KIND_PUSH_MEM:
                if (seg_fill >= DEPTH) o.status = ST_FULL;
                else
                begin
                    slot = (seg_head + seg_fill) % DEPTH;
                    seg_addr[slot] = r.mem_address;
                    seg_len[slot] = r.mem_length;
                    seg_fill++;
                end
            KIND_PUSH_FILE:
                if (ext_fill >= DEPTH) o.status = ST_FULL;
                else
                begin
                    slot = (ext_head + ext_fill) % DEPTH;
                    ext_off[slot] = r.file_offset;
                    ext_len[slot] = r.file_length;
                    ext_fill++;
                end
            KIND_REQUEST:
                if (seg_fill == 0 || ext_fill == 0) o.status = ST_EMPTY;
                else
                begin
                    sb = (stripe_reg == 0) ? 64'd1 : 64'(stripe_reg);
                    tc = (targets_reg == 0) ? 64'd1 : 64'(targets_reg);
                    if (tc > 64'(MAX_TARGETS_DEF)) tc = 64'(MAX_TARGETS_DEF);
                    off = {1'b0, 63'(ext_off[ext_head] + 63'(ext_used))};
                    left = sb - off % sb;
                    len = 64'(ext_len[ext_head]) - 64'(ext_used);
                    if (left < len) len = left;
                    if (64'(seg_len[seg_head]) - 64'(seg_used) < len)
                        len = 64'(seg_len[seg_head]) - 64'(seg_used);
                    o.status = ST_PIECE;
                    o.target = 6'((off / sb) % tc);
                    o.piece_address = seg_addr[seg_head] + 64'(seg_used);
                    o.piece_offset = off[62:0];
                    o.piece_length = len[39:0];
                    seg_used = seg_used + len[39:0];
                    ext_used = ext_used + len[39:0];
                    if (seg_used >= seg_len[seg_head])
                    begin
                        seg_head = (seg_head + 1) % DEPTH;
                        seg_fill--;
                        seg_used = '0;
                    end
                    if (ext_used >= ext_len[ext_head])
                    begin
                        ext_head = (ext_head + 1) % DEPTH;
                        ext_fill--;
                        ext_used = '0;
                    end
                end
            default:
            begin
                seg_head = 0; seg_fill = 0; ext_head = 0; ext_fill = 0;
                seg_used = '0; ext_used = '0;
            end
        endcase
        return o;
    endfunction

    // driver
    always @(posedge clk)
    begin
        in_item_t nxt;
        if (s_axis_tvalid && s_axis_tready)
            expected_results = {expected_results,
                split_step(in_item_t'({s_axis_tdata[IN_BITS-1:0], s_axis_tuser}))};
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (request_queue.size() > 0 && rst_n &&
                $urandom_range(99, 0) >= send_idle_pct)
            begin
                nxt = request_queue.pop_front();
                s_axis_tuser <= nxt.kind;
                s_axis_tdata <= IN_W'(nxt[IN_BITS+1:2]);
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = out_item_t'({m_axis_tdata[OUT_BITS-1:0], m_axis_tuser});
            if (expected_results.size() == 0)
                report("unexpected result", 200'(got), '0);
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    report("status", 200'(got.status), 200'(want.status));
                if (got.target != want.target)
                    report("target", 200'(got.target), 200'(want.target));
                if (got.piece_address != want.piece_address)
                    report("address", 200'(got.piece_address), 200'(want.piece_address));
                if (got.piece_offset != want.piece_offset)
                    report("offset", 200'(got.piece_offset), 200'(want.piece_offset));
                if (got.piece_length != want.piece_length)
                    report("length", 200'(got.piece_length), 200'(want.piece_length));
            end
        end
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    function automatic in_item_t make_item(input logic [1:0] k, input logic [63:0] a,
                                           input logic [39:0] ml, input logic [62:0] fo,
                                           input logic [39:0] fl);
        in_item_t r;
        r.kind = k; r.mem_address = a; r.mem_length = ml;
        r.file_offset = fo; r.file_length = fl;
        return r;
    endfunction

    function automatic logic [39:0] rand_len();
        case ($urandom_range(5, 0))
            0: return 40'($urandom_range(3, 0));
            1: return 40'({$urandom, $urandom});
            2: return 40'hFF_FFFF_FFFF - 40'($urandom_range(3, 0));
            default: return 40'($urandom_range(5000, 1));
        endcase
    endfunction

    function automatic in_item_t rand_item(input logic [1:0] k);
        return make_item(k, {$urandom, $urandom}, rand_len(),
                         63'({$urandom, $urandom}) >> $urandom_range(40, 0), rand_len());
    endfunction

    task automatic write_reg(input logic idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STRIPE_BYTES) stripe_reg = val; else targets_reg = val[6:0];
    endtask

    task automatic drain();
        while (request_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 30) add_request(rand_item(KIND_PUSH_MEM));
            else if (r < 60) add_request(rand_item(KIND_PUSH_FILE));
            else if (r < 97) add_request(rand_item(KIND_REQUEST));
            else add_request(rand_item(KIND_CLEAR));
        end
        drain();
    endtask

    initial
    begin
        seg_head = 0; seg_fill = 0; ext_head = 0; ext_fill = 0;
        seg_used = '0; ext_used = '0;
        stripe_reg = 31'd1048576; targets_reg = 7'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty request, extremes, zero lengths, stripe crossing, full queue, clear
        add_request(make_item(KIND_REQUEST, '0, '0, '0, '0));
        add_request(make_item(KIND_PUSH_MEM, '1, 40'd0, '0, '0));
        add_request(make_item(KIND_PUSH_FILE, '0, '0, '1, 40'hFF_FFFF_FFFF));
        add_request(make_item(KIND_REQUEST, '0, '0, '0, '0));
        add_request(make_item(KIND_PUSH_MEM, 64'h10, 40'hFF_FFFF_FFFF, '0, '0));
        add_request(make_item(KIND_REQUEST, '0, '0, '0, '0));
        add_request(make_item(KIND_REQUEST, '0, '0, '0, '0));
        for (int i = 0; i < 17; i++)
            add_request(rand_item(KIND_PUSH_FILE));
        add_request(make_item(KIND_CLEAR, '1, '1, '1, '1));
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_STRIPE_BYTES, 31'd0); write_reg(REG_TARGET_COUNT, 31'd0); end
                1: begin write_reg(REG_STRIPE_BYTES, 31'h7FFF_FFFF);
                         write_reg(REG_TARGET_COUNT, 31'd127); end
                2: begin write_reg(REG_STRIPE_BYTES, 31'd1000); write_reg(REG_TARGET_COUNT, 31'd64); end
                3: begin write_reg(REG_STRIPE_BYTES, 31'd1); write_reg(REG_TARGET_COUNT, 31'd5); end
                default: begin write_reg(REG_STRIPE_BYTES, 31'd4096);
                               write_reg(REG_TARGET_COUNT, 31'd1); end
            endcase
            send_idle_pct = (ph == 1 || ph == 4) ? 72 : (ph == 3 ? 38 : 0);
            recv_stall_pct = (ph == 2 || ph == 4) ? 72 : (ph == 3 ? 38 : 0);
            random_phase(110);
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
